@@ rtl/idps_pkg.sv @@
`timescale 1ns / 1ps

package idps_pkg;

    // fp32 constants
    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG     = 31'h7F80_0000;
    localparam logic [7:0]  EXP_MAX     = 8'hFF;
    localparam int          MANT_W      = 24;
    localparam int          RAW_W       = 20;

    // controller to datapath commands
    typedef struct packed {
        logic acc;    // element beat accepted
        logic mul;    // form mantissa times magnitude
        logic norm;   // one normalize shift
        logic load;   // load result register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic norm_done;
    } t_status;

endpackage

@@ rtl/idps_ctrl.sv @@
`timescale 1ns / 1ps

module idps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last_element,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  idps_pkg::t_status  i_status,
    output idps_pkg::t_cmd     o_cmd
);
    import idps_pkg::*;

    typedef enum logic [3:0] {
        S_ACC  = 4'b0001,
        S_MUL  = 4'b0010,
        S_NORM = 4'b0100,
        S_RND  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_out_take;
    logic   w_in_take;

    assign w_out_take  = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;

    // input stalls outside accumulate; there the closing beat waits until the result register can take it
    always_comb begin
        o_in_stall = 1'b1;
        if (r_state == S_ACC) begin
            o_in_stall = i_last_element && r_out_valid && i_out_stall;
        end
    end

    assign w_in_take = i_in_valid && !o_in_stall;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.acc  = w_in_take;
        case (r_state)
            S_ACC: begin
                if (w_in_take && i_last_element) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_NORM;
            end
            S_NORM: begin
                if (i_status.norm_done) n_state = S_RND;
                else o_cmd.norm = 1'b1;
            end
            S_RND: begin
                o_cmd.load = 1'b1;
                n_state    = S_ACC;
            end
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) r_out_valid <= 1'b1;
            else if (w_out_take) r_out_valid <= 1'b0;
        end
    end

endmodule

@@ rtl/idps_dpath.sv @@
`timescale 1ns / 1ps

module idps_dpath #(
    parameter int MAX_LENGTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  idps_pkg::t_cmd     i_cmd,
    output idps_pkg::t_status  o_status,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [7:0]  i_element_a,
    input  logic signed [7:0]  i_element_b,
    input  logic               i_last_element,
    output logic [31:0]        o_score_bits,
    output logic signed [19:0] o_raw_sum,
    output logic               o_length_error
);
    import idps_pkg::*;

    localparam int SUM_W = 16 + $clog2(MAX_LENGTH);
    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int PW    = MANT_W + SUM_W;
    localparam int XW    = 10;

    logic [31:0]             r_scale;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_ovf, n_ovf;
    logic signed [SUM_W-1:0] r_fsum;
    logic                    r_ferr;
    logic [PW-1:0]           r_p;
    logic [XW-1:0]           r_x;
    logic signed [15:0]      w_prod;
    logic [SUM_W-1:0]        w_mag;
    logic [MANT_W-1:0]       w_mant;
    logic [7:0]              w_exp;
    logic                    w_sign;
    logic                    w_inc;
    logic [7:0]              w_expf;
    logic [30:0]             w_rnd;
    logic [31:0]             n_score;
    logic signed [31:0]      w_sum_ext;

    // scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_scale <= SCALE_RESET;
        else if (i_cfg_valid) r_scale <= i_cfg_data;
    end

    // multiply-accumulate with length check
    assign w_prod = i_element_a * i_element_b;

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (r_cnt == CNT_W'(MAX_LENGTH)) begin
            n_ovf = 1'b1;
        end else begin
            n_sum = r_sum + SUM_W'(w_prod);
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.acc) begin
            if (i_last_element) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
            end
        end
    end

    // closed vector
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && i_last_element) begin
            r_fsum <= n_sum;
            r_ferr <= n_ovf;
        end
    end

    // scale fields, subnormal scale has no hidden bit and exponent one
    assign w_exp  = (r_scale[30:23] == 8'd0) ? 8'd1 : r_scale[30:23];
    assign w_mant = {(r_scale[30:23] != 8'd0), r_scale[22:0]};
    assign w_mag  = r_fsum[SUM_W-1] ? SUM_W'(-r_fsum) : SUM_W'(r_fsum);
    assign w_sign = r_scale[31] ^ r_fsum[SUM_W-1];

    // mantissa product, then shift left until normalized, at minimum exponent or zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p <= PW'(w_mant) * PW'(w_mag);
            r_x <= XW'(w_exp) + XW'(PW - MANT_W);
        end else if (i_cmd.norm) begin
            r_p <= r_p << 1;
            r_x <= r_x - 1'b1;
        end
    end

    assign o_status.norm_done = r_p[PW-1] || (r_x <= XW'(1)) || (r_p == '0);

    // round to nearest even, carry may move into exponent
    assign w_inc  = r_p[PW-MANT_W-1] && (r_p[PW-MANT_W] || (|r_p[PW-MANT_W-2:0]));
    assign w_expf = r_p[PW-1] ? r_x[7:0] : 8'd0;
    assign w_rnd  = {w_expf, r_p[PW-2:PW-MANT_W]} + 31'(w_inc);

    // special cases then rounded score
    always_comb begin
        if (r_scale[30:23] == EXP_MAX && r_scale[22:0] != 23'd0) begin
            n_score = r_scale | QUIET_BIT;
        end else if (r_scale[30:23] == EXP_MAX) begin
            n_score = (r_fsum == '0) ? DEFAULT_NAN : {w_sign, INF_MAG};
        end else if (r_p == '0) begin
            n_score = {w_sign, 31'd0};
        end else if (r_x >= XW'(255)) begin
            n_score = {w_sign, INF_MAG};
        end else begin
            n_score = {w_sign, w_rnd};
        end
    end

    assign w_sum_ext = 32'(r_fsum);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_length_error <= r_ferr;
            o_score_bits   <= r_ferr ? 32'd0 : n_score;
            o_raw_sum      <= r_ferr ? 20'sd0 : w_sum_ext[RAW_W-1:0];
        end
    end

endmodule

@@ rtl/int8_dot_product_scaled_unit.sv @@
`timescale 1ns / 1ps

// Quantized int8 dot product with fp32 scaling. Element pairs are taken one beat
// per cycle when not stalled and summed; the beat marked last closes the vector
// and yields one result: the integer sum and the fp32 score scale times sum (round
// to nearest even, NaN and infinity propagated), or score 0 with length_error set
// when the vector held more than MAX_LENGTH pairs. After a last beat the input
// stalls while the product is formed, normalized (0 to 20 shifts with MAX_LENGTH
// 16, at most 16 + log2(MAX_LENGTH), one bit per cycle in the shifter) and
// rounded. The closing beat also stalls while an earlier result is still held in
// the output register. Scale is written through the cfg port, ready always high.
module int8_dot_product_scaled_unit #(
    parameter int MAX_LENGTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [7:0]  i_element_a,
    input  logic signed [7:0]  i_element_b,
    input  logic               i_last_element,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_score_bits,
    output logic signed [19:0] o_raw_sum,
    output logic               o_length_error
);
    import idps_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    idps_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_last_element (i_last_element),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (w_status),
        .o_cmd          (w_cmd)
    );

    // arithmetic
    idps_dpath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_element_a    (i_element_a),
        .i_element_b    (i_element_b),
        .i_last_element (i_last_element),
        .o_score_bits   (o_score_bits),
        .o_raw_sum      (o_raw_sum),
        .o_length_error (o_length_error)
    );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import idps_pkg::*;

    localparam int MAX_LEN     = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_GAP   = 320;

    typedef struct {
        logic [31:0] score;
        logic [19:0] raw;
        logic        err;
    } dot_result_t;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_valid    = 1'b0;
    logic [31:0]       i_cfg_data     = '0;
    logic              i_in_valid     = 1'b0;
    logic signed [7:0] i_element_a    = '0;
    logic signed [7:0] i_element_b    = '0;
    logic              i_last_element = 1'b0;
    logic              i_out_stall    = 1'b0;
    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [31:0]       o_score_bits;
    logic signed [19:0] o_raw_sum;
    logic              o_length_error;

    // predictor state
    logic [31:0] scale_reg = SCALE_RESET;
    int          dot_acc   = 0;
    int          pair_cnt  = 0;
    logic        too_long  = 1'b0;
    dot_result_t pending_results[$];

    int mismatches  = 0;
    int cycle_cnt   = 0;
    int src_idle    = 0;
    int snk_idle    = 0;

    int8_dot_product_scaled_unit #(.MAX_LENGTH(MAX_LEN)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_element_a(i_element_a), .i_element_b(i_element_b),
        .i_last_element(i_last_element),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_score_bits(o_score_bits), .o_raw_sum(o_raw_sum),
        .o_length_error(o_length_error)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // fp32 product of scale and integer sum, round to nearest even
    function automatic logic [31:0] fp32_scale_sum(logic [31:0] s, int sum);
        logic [7:0]      ex;
        logic [22:0]     fr;
        logic            sg;
        longint unsigned mag, prod, q, rem, half;
        int              e, p, sh, be;
        ex = s[30:23];
        fr = s[22:0];
        sg = s[31] ^ (sum < 0);
        if (ex == EXP_MAX && fr != 0) return s | QUIET_BIT;
        if (ex == EXP_MAX) return (sum == 0) ? DEFAULT_NAN : {sg, INF_MAG};
        mag  = (sum < 0) ? longint'(-sum) : longint'(sum);
        prod = longint'({ex != 0, fr}) * mag;
        e    = (ex == 0) ? 1 : int'(ex);
        if (prod == 0) return {sg, 31'b0};
        p = 63;
        while (!prod[p]) p--;
        sh = p - 23;
        be = p + e - 23;
        // below normal range: shift into subnormal position
        if (be < 1) begin
            sh += 1 - be;
            be = 0;
        end
        if (sh <= 0) q = prod << (-sh);
        else if (sh > p + 1) q = 0;
        else begin
            q    = prod >> sh;
            rem  = prod - (q << sh);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q++;
        end
        if (be > 0) begin
            if (q[24]) begin
                q  = q >> 1;
                be++;
            end
            if (be >= 255) return {sg, INF_MAG};
            return {sg, be[7:0], q[22:0]};
        end
        // a carry into bit 23 lands in the exponent field by itself
        return {sg, q[30:0]};
    endfunction

    // fold one accepted pair into the expected sums
    task automatic fold_pair(logic signed [7:0] a, logic signed [7:0] b, logic last);
        dot_result_t r;
        if (pair_cnt >= MAX_LEN) too_long = 1'b1;
        else begin
            dot_acc += int'(a) * int'(b);
            pair_cnt++;
        end
        if (last) begin
            if (too_long) begin
                r.score = '0;
                r.raw   = '0;
                r.err   = 1'b1;
            end else begin
                r.score = fp32_scale_sum(scale_reg, dot_acc);
                r.raw   = dot_acc[19:0];
                r.err   = 1'b0;
            end
            pending_results.push_back(r);
            dot_acc  = 0;
            pair_cnt = 0;
            too_long = 1'b0;
        end
    endtask

    // send one element beat and wait until it is taken
    task automatic send_pair(logic signed [7:0] a, logic signed [7:0] b, logic last);
        if ($urandom_range(99) < src_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_element_a    <= a;
        i_element_b    <= b;
        i_last_element <= last;
        do @(posedge i_clk); while (o_in_stall);
        fold_pair(a, b, last);
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // scale write, only with the block idle
    task automatic write_scale(logic [31:0] val);
        wait_results_done();
        repeat (DRAIN_GAP) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        scale_reg = val;
    endtask

    // random element, extremes weighted up
    function automatic logic signed [7:0] pick_elem();
        case ($urandom_range(7))
            0: return 8'sh80;
            1: return 8'sh7F;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic send_vector(int len, logic all_min);
        for (int k = 0; k < len; k++) begin
            if (all_min) send_pair(8'sh80, 8'sh80, k == len - 1);
            else send_pair(pick_elem(), pick_elem(), k == len - 1);
        end
    endtask

    function automatic logic [31:0] pick_scale();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(3))
            0: return v;
            1: return {v[31], 8'd110 + v[7:0] % 8'd30, v[22:0]};
            2: return {v[31], 8'd200 + v[7:0] % 8'd55, v[22:0]};
            default: return {v[31], 8'd0 + v[7:0] % 8'd3, v[22:0]};
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        dot_result_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat score=%h", o_score_bits);
            end else begin
                e = pending_results.pop_front();
                if (o_score_bits !== e.score || o_raw_sum !== e.raw
                        || o_length_error !== e.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp score=%h raw=%h err=%b, got %h %h %b",
                                 e.score, e.raw, e.err, o_score_bits, o_raw_sum,
                                 o_length_error);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < snk_idle);
    end

    // extremes, single pair, exact error boundary
    task automatic test_directed();
        send_pair(8'sh00, 8'sh00, 1'b1);
        send_pair(8'sh80, 8'sh7F, 1'b1);
        send_pair(8'sh7F, 8'sh7F, 1'b1);
        send_pair(8'shFF, 8'sh01, 1'b1);
        send_vector(MAX_LEN, 1'b1);
        send_vector(MAX_LEN + 1, 1'b0);
        send_vector(MAX_LEN + 2, 1'b1);
        send_pair(8'sh55, 8'shAA, 1'b1);
    endtask

    // special scale values
    task automatic test_scales();
        logic [31:0] specials [12];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_1234, 32'h7F80_0001, 32'hFF80_0055, 32'h7F7F_FFFF,
                     32'h0000_0001, 32'h0080_0000, 32'hFFFF_FFFF, 32'h3F80_0001};
        foreach (specials[i]) begin
            write_scale(specials[i]);
            send_pair(8'sh00, 8'sh11, 1'b1);
            send_pair(8'sh80, 8'sh7F, 1'b1);
            send_vector(3, 1'b0);
        end
        write_scale(SCALE_RESET);
    endtask

    task automatic test_random(int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(15) == 0) write_scale(pick_scale());
            if ($urandom_range(30) == 0) wait_results_done();
            len = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN + 1, MAX_LEN + 4)
                                           : $urandom_range(1, MAX_LEN);
            send_vector(len, $urandom_range(20) == 0);
            sent += len;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_scales();
        src_idle = 17;
        snk_idle = 75;
        test_random(200);
        src_idle = 75;
        snk_idle = 17;
        test_random(190);
        src_idle = 0;
        snk_idle = 0;
        test_random(190);
        wait_results_done();
        repeat (DRAIN_GAP) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end

endmodule
